### rtl/core/lrfp_pkg.sv
// ----------------------------------------------------------------------------
// lrfp_pkg
// Shared widths, constants and types of the likelihood rate solver.
// ----------------------------------------------------------------------------
package lrfp_pkg;

    localparam int MaxSamples = 4096;
    localparam int FracBits   = 32;
    localparam int ValW       = 56;
    localparam int AddrW      = $clog2(MaxSamples);
    localparam int CntW       = $clog2(MaxSamples + 1);
    localparam int DivSteps   = ValW + FracBits;
    localparam int DivCntW    = $clog2(DivSteps + 1);

    localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};
    localparam logic [ValW-1:0] OneQ   = ValW'(64'd1 << FracBits);

    localparam logic [1:0] CfgUnitBg  = 2'd0;
    localparam logic [1:0] CfgTol     = 2'd1;
    localparam logic [1:0] CfgFloor   = 2'd2;
    localparam logic [1:0] CfgIterLim = 2'd3;

    localparam logic [1:0] StConverged = 2'd0;
    localparam logic [1:0] StFloor     = 2'd1;
    localparam logic [1:0] StLimit     = 2'd2;

    typedef struct packed {
        logic            start;
        logic [ValW-1:0] num;
        logic [ValW-1:0] den;
    } lrfp_div_req_t;

    typedef struct packed {
        logic            done;
        logic [ValW-1:0] quo;
    } lrfp_div_rsp_t;

    typedef struct packed {
        logic            start;
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
    } lrfp_mul_req_t;

    typedef struct packed {
        logic            done;
        logic [ValW-1:0] prod;
    } lrfp_mul_rsp_t;

    function automatic logic [ValW-1:0] add_sat(input logic [ValW-1:0] a,
                                                 input logic [ValW-1:0] b);
        logic [ValW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ValW] ? ValMax : s[ValW-1:0];
    endfunction

endpackage

### rtl/core/lrfp_div.sv
// ----------------------------------------------------------------------------
// lrfp_div
// Restoring divider, floor(a * 2^FracBits / d), one quotient bit per cycle,
// saturating on overflow and on a zero divisor.
// ----------------------------------------------------------------------------
module lrfp_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lrfp_pkg::lrfp_div_req_t req,
    output lrfp_pkg::lrfp_div_rsp_t rsp
);
    import lrfp_pkg::*;

    logic                busy_reg;
    logic [DivCntW-1:0]  pos_reg;
    logic [ValW-1:0]     num_reg;
    logic [ValW-1:0]     den_reg;
    logic [ValW:0]       rem_reg;
    logic [ValW-1:0]     quo_reg;
    logic                sat_reg;
    logic                done_reg;

    logic [ValW:0]       rem_sh;
    logic                bit_in;
    logic                ge;
    logic [ValW:0]       rem_sub;

    always_comb begin
        bit_in  = (pos_reg >= DivCntW'(FracBits)) ?
                  num_reg[ValW-1] : 1'b0;
        rem_sh  = {rem_reg[ValW-1:0], bit_in};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= (req.den != '0);
            done_reg <= (req.den == '0);
            sat_reg  <= (req.den == '0);
            pos_reg  <= DivCntW'(DivSteps - 1);
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end else if (busy_reg) begin
            if (pos_reg >= DivCntW'(FracBits)) begin
                num_reg <= {num_reg[ValW-2:0], 1'b0};
            end
            rem_reg <= ge ? rem_sub : rem_sh;
            if (ge && pos_reg >= DivCntW'(ValW)) begin
                sat_reg <= 1'b1;
            end
            quo_reg <= {quo_reg[ValW-2:0], ge};
            if (pos_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                pos_reg <= pos_reg - 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sat_reg ? ValMax : quo_reg;

endmodule

### rtl/core/lrfp_mul.sv
// ----------------------------------------------------------------------------
// lrfp_mul
// Fixed-point multiplier, floor(a*b / 2^FracBits) saturated, built from four
// 28 x 28 partial products accumulated in turn.
// ----------------------------------------------------------------------------
module lrfp_mul (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lrfp_pkg::lrfp_mul_req_t req,
    output lrfp_pkg::lrfp_mul_rsp_t rsp
);
    import lrfp_pkg::*;

    localparam int HalfW = ValW / 2;
    localparam int FullW = 2 * ValW;

    logic             busy_reg;
    logic [1:0]       step_reg;
    logic [ValW-1:0]  a_reg;
    logic [ValW-1:0]  b_reg;
    logic [FullW-1:0] acc_reg;
    logic             done_reg;

    logic [HalfW-1:0]   pa;
    logic [HalfW-1:0]   pb;
    logic [ValW-1:0]    pp;
    logic [FullW-1:0]   pp_sh;
    logic [FullW-1:0]   shifted;

    always_comb begin
        pa = step_reg[0] ? a_reg[ValW-1:HalfW] : a_reg[HalfW-1:0];
        pb = step_reg[1] ? b_reg[ValW-1:HalfW] : b_reg[HalfW-1:0];
        pp = pa * pb;
        pp_sh = FullW'(pp) << (HalfW * (32'(step_reg[0]) + 32'(step_reg[1])));
        shifted = acc_reg >> FracBits;
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            a_reg    <= req.a;
            b_reg    <= req.b;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            acc_reg  <= acc_reg + pp_sh;
            step_reg <= step_reg + 1'b1;
            if (step_reg == 2'd3) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = (shifted[FullW-1:ValW] != '0) ? ValMax : shifted[ValW-1:0];

endmodule

### rtl/core/lrfp_store.sv
// ----------------------------------------------------------------------------
// lrfp_store
// Event memory: weight and background per entry, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module lrfp_store (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [lrfp_pkg::AddrW-1:0]   wr_addr,
    input  logic [lrfp_pkg::ValW-1:0]    wr_weight,
    input  logic [lrfp_pkg::ValW-1:0]    wr_bg,
    input  logic [lrfp_pkg::AddrW-1:0]   rd_addr,
    output logic [lrfp_pkg::ValW-1:0]    rd_weight,
    output logic [lrfp_pkg::ValW-1:0]    rd_bg
);
    import lrfp_pkg::*;

    logic [2*ValW-1:0] mem [MaxSamples];
    logic [2*ValW-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_bg, wr_weight};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_weight = rd_reg[ValW-1:0];
    assign rd_bg     = rd_reg[2*ValW-1:ValW];

endmodule

### rtl/core/likelihood_rate_fixed_point.sv
// ----------------------------------------------------------------------------
// likelihood_rate_fixed_point
// Poisson maximum-likelihood rate solver by fixed-point iteration, Q24.32.
// ----------------------------------------------------------------------------
// Each input transfer stores one event (weight, background) in memory at one
// transfer per cycle. The transfer with tlast set is stored too and then
// starts the solve using its start rate and exposure; no input transfer is
// taken until the single result transfer has been accepted downstream.
// Per event and iteration the block reads the event from memory (S_RD, S_RDW),
// then waits for the shared multiplier and then for the shared 88-step
// divider; each request goes out only after the step before it has answered.
// The solve runs for up to iteration_limit iterations. Throughput during the
// solve is set by the single divider.
// The result stays on m_axis until m_axis_tready; the block simply waits.
// Reset empties the event memory (by its fill count) and restores the
// register defaults; memory contents are not cleared.
// Events beyond 4096 in one set are dropped.
// ----------------------------------------------------------------------------
module likelihood_rate_fixed_point (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [55:0]   cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // sample_weight[55:0], background_level[111:56], start_rate[167:112],
    // exposure_time[223:168]
    input  logic [223:0]  s_axis_tdata,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // rate_estimate[55:0], iterations_used[63:56], exit_status[65:64], zeros
    output logic [71:0]   m_axis_tdata
);
    import lrfp_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_ITER, S_RD, S_RDW, S_MUL1, S_DIV1, S_ACC,
        S_MUL2, S_DIV2, S_MUL3, S_CHECK, S_OUT
    } state_t;

    state_t          state_reg;
    logic            unit_bg_reg;
    logic [31:0]     tol_reg;
    logic [ValW-1:0] floor_reg;
    logic [7:0]      lim_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] idx_reg;
    logic [ValW-1:0] rate_reg;
    logic [ValW-1:0] rnew_reg;
    logic [ValW-1:0] expo_reg;
    logic [ValW-1:0] sum_reg;
    logic [ValW-1:0] s_reg;
    logic [ValW-1:0] b_reg;
    logic [7:0]      iter_reg;
    logic [1:0]      status_reg;
    logic            pend_reg;

    lrfp_mul_req_t mreq;
    lrfp_mul_rsp_t mrsp;
    lrfp_div_req_t dreq;
    lrfp_div_rsp_t drsp;

    logic [ValW-1:0] rd_w;
    logic [ValW-1:0] rd_b;
    logic            wr_en;
    logic [ValW-1:0] diff;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign wr_en = s_axis_tvalid && s_axis_tready && (count_reg < CntW'(MaxSamples));
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {6'd0, status_reg, iter_reg, rnew_reg};
    assign diff = (drsp.quo > rate_reg) ? drsp.quo - rate_reg : rate_reg - drsp.quo;

    lrfp_store u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[AddrW-1:0]),
        .wr_weight(s_axis_tdata[55:0]),
        .wr_bg    (s_axis_tdata[111:56]),
        .rd_addr  (idx_reg[AddrW-1:0]),
        .rd_weight(rd_w),
        .rd_bg    (rd_b)
    );

    lrfp_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));
    lrfp_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    always_ff @(posedge aclk) begin
        mreq.start <= 1'b0;
        dreq.start <= 1'b0;
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            unit_bg_reg <= 1'b0;
            tol_reg     <= 32'd429;
            floor_reg   <= OneQ;
            lim_reg     <= 8'd200;
            count_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CfgUnitBg:  unit_bg_reg <= cfg_wdata[0];
                    CfgTol:     tol_reg     <= cfg_wdata[31:0];
                    CfgFloor:   floor_reg   <= cfg_wdata;
                    CfgIterLim: lim_reg     <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_LOAD: begin
                    if (s_axis_tvalid) begin
                        if (wr_en) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (s_axis_tlast) begin
                            rate_reg   <= s_axis_tdata[167:112];
                            rnew_reg   <= s_axis_tdata[167:112];
                            expo_reg   <= s_axis_tdata[223:168];
                            iter_reg   <= '0;
                            status_reg <= StLimit;
                            state_reg  <= S_ITER;
                        end
                    end
                end
                S_ITER: begin
                    if (iter_reg >= lim_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        sum_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= (count_reg == '0) ? S_MUL2 : S_RD;
                        pend_reg  <= (count_reg == '0);
                    end
                end
                S_RD: state_reg <= S_RDW;
                S_RDW: begin
                    s_reg      <= rd_w;
                    b_reg      <= unit_bg_reg ? OneQ : rd_b;
                    mreq.start <= 1'b1;
                    mreq.a     <= rd_w;
                    mreq.b     <= rate_reg;
                    state_reg  <= S_MUL1;
                end
                S_MUL1: begin
                    if (mrsp.done) begin
                        dreq.start <= 1'b1;
                        dreq.num   <= s_reg;
                        dreq.den   <= add_sat(mrsp.prod, b_reg);
                        state_reg  <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (drsp.done) begin
                        sum_reg   <= add_sat(sum_reg, drsp.quo);
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    state_reg <= (idx_reg == count_reg) ? S_MUL2 : S_RD;
                    pend_reg  <= (idx_reg == count_reg);
                end
                S_MUL2: begin
                    if (pend_reg) begin
                        pend_reg   <= 1'b0;
                        mreq.start <= 1'b1;
                        mreq.a     <= sum_reg;
                        mreq.b     <= rate_reg;
                    end else if (mrsp.done) begin
                        dreq.start <= 1'b1;
                        dreq.num   <= mrsp.prod;
                        dreq.den   <= expo_reg;
                        state_reg  <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (drsp.done) begin
                        rnew_reg <= drsp.quo;
                        iter_reg <= iter_reg + 1'b1;
                        if (diff < {24'd0, tol_reg}) begin
                            status_reg <= StConverged;
                            state_reg  <= S_OUT;
                        end else begin
                            mreq.start <= 1'b1;
                            mreq.a     <= drsp.quo;
                            mreq.b     <= expo_reg;
                            state_reg  <= S_MUL3;
                        end
                    end
                end
                S_MUL3: begin
                    if (mrsp.done) begin
                        if (mrsp.prod < floor_reg) begin
                            status_reg <= StFloor;
                            state_reg  <= S_OUT;
                        end else begin
                            rate_reg  <= rnew_reg;
                            state_reg <= S_ITER;
                        end
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        count_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule
